[src/rtpjb_pkg.sv]
// Shared types, constants and codes for the RTP jitter buffer.
`default_nettype none
package rtpjb_pkg;

  localparam int unsigned MaxEntriesDef = 64;

  localparam logic [17:0] RateRst     = 18'd8000;
  localparam logic [15:0] MinDelayRst = 16'd20;
  localparam logic [15:0] MaxDelayRst = 16'd500;
  localparam logic [15:0] InitDelayRst = 16'd60;

  localparam logic [15:0] DelayUp   = 16'd10;
  localparam logic [15:0] DelayDown = 16'd5;
  localparam logic [15:0] LossGapLimit = 16'd100;
  localparam logic [9:0]  MsPerSec  = 10'd1000;

  typedef enum logic [1:0] {
    FUNC_INSERT  = 2'd0,
    FUNC_EXTRACT = 2'd1,
    FUNC_CLEAR   = 2'd2,
    FUNC_NOP     = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    REG_RATE      = 2'd0,
    REG_MIN_DELAY = 2'd1,
    REG_MAX_DELAY = 2'd2,
    REG_INIT_DELAY = 2'd3
  } reg_idx_t;

  // Divider request / response between top level and the divider.
  typedef struct packed {
    logic        start;
    logic [41:0] dividend;
    logic [17:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [41:0] quotient;
  } div_rsp_t;

endpackage
`default_nettype wire

[src/rtp_jitter_buffer.sv]
// Top level of the RTP adaptive jitter buffer.
//
// Channel  Direction  Content
// in_      slave      tdata = seq, rtp_timestamp, arrival time, packet_handle; tuser = func
// out_     master     tdata = hit, out_handle, out_seq, delay, jitter, lost, fill
// cfg_     slave      cfg_index (2 bit register number), cfg_data (18 bit)
//
// Sequence: an insert runs the timestamp divide, then moves larger entries
//   up one slot to open its slot, then marks each held entry ready or not;
//   on overflow it then drops the lowest entry. Extract skips entries that are
//   not ready, then closes the gap behind the one it takes. Clear and no-op go
//   straight to the result.
// Reset: rst_n clears the control state and valid flags; descriptor memory is
//   not cleared since only held entries are ever read.
// Stalls: the result sits in an output register; a new transaction is taken
//   only after the result has been accepted downstream.
`default_nettype none
module rtp_jitter_buffer #(
  parameter int unsigned MAX_ENTRIES = rtpjb_pkg::MaxEntriesDef
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // [15:0] seq, [47:16] rtp_timestamp, [79:48] arrival time, [95:80] packet_handle
  input  wire logic [95:0]  in_tdata,
  // [1:0] func
  input  wire logic [1:0]   in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // [0] hit, [16:1] out_handle, [32:17] out_seq, [48:33] delay_now_ms,
  // [80:49] jitter_now_ms, [112:81] lost_total, [119:113] fill_count, rest 0
  output logic [127:0]      out_tdata,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [17:0]  cfg_data
);
  localparam int unsigned Slots = MAX_ENTRIES + 1;
  localparam int unsigned AW = $clog2(Slots);
  localparam int unsigned CW = $clog2(Slots + 1);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_DIV    = 10'b0000000010,
    S_JIT    = 10'b0000000100,
    S_SHIFT  = 10'b0000001000,
    S_DEPTH  = 10'b0000010000,
    S_READY  = 10'b0000100000,
    S_ADAPT  = 10'b0001000000,
    S_FIND   = 10'b0010000000,
    S_REMOVE = 10'b0100000000,
    S_OUT    = 10'b1000000000
  } state_t;

  // Descriptor memory; one write and one registered read per cycle.
  logic [63:0] mem [Slots];
  logic [63:0] rd_r;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [63:0] wr_data;
  logic wr_en;
  logic [Slots-1:0] rdy_r, rdy_nxt;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_r <= mem[rd_addr];
  end

  state_t state_r, state_nxt;
  logic [17:0] rate_r, rate_nxt;
  logic [15:0] min_r, min_nxt, max_r, max_nxt, init_r, init_nxt;
  logic [CW-1:0] occ_r, occ_nxt;
  logic [15:0] nexp_r, nexp_nxt;
  logic seqst_r, seqst_nxt, jst_r, jst_nxt;
  logic [31:0] ptr_r, ptr_nxt, jit_r, jit_nxt;
  logic [15:0] dly_r, dly_nxt;
  logic [31:0] loss_r, loss_nxt;
  logic [1:0] func_r, func_nxt;
  logic [15:0] seq_r, seq_nxt, hnd_r, hnd_nxt;
  logic [31:0] ts_r, ts_nxt, now_r, now_nxt;
  logic [AW-1:0] ptr_i_r, ptr_i_nxt;
  logic phase_r, phase_nxt;
  logic [31:0] first_r, first_nxt;
  logic [31:0] depth_r, depth_nxt;
  logic hit_r, hit_nxt;
  logic [15:0] oh_r, oh_nxt, os_r, os_nxt;
  logic ovalid_r, ovalid_nxt;
  rtpjb_pkg::div_req_t dreq;
  rtpjb_pkg::div_rsp_t drsp;

  rtpjb_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  logic [31:0] transit, udiff, dabs;
  logic signed [32:0] stepd;
  logic [15:0] gap;
  logic [15:0] up16;
  logic [16:0] up17;

  assign in_tready = (state_r == S_IDLE) && !ovalid_r;
  assign cfg_ready = 1'b1;
  assign out_tvalid = ovalid_r;
  assign out_tdata = {8'd0, 7'(occ_r), loss_r, jit_r, dly_r, os_r, oh_r, hit_r};

  always_comb begin
    state_nxt = state_r; rate_nxt = rate_r; min_nxt = min_r; max_nxt = max_r;
    init_nxt = init_r; occ_nxt = occ_r; nexp_nxt = nexp_r; seqst_nxt = seqst_r;
    jst_nxt = jst_r; ptr_nxt = ptr_r; jit_nxt = jit_r; dly_nxt = dly_r;
    loss_nxt = loss_r; func_nxt = func_r; seq_nxt = seq_r; hnd_nxt = hnd_r;
    ts_nxt = ts_r; now_nxt = now_r; ptr_i_nxt = ptr_i_r; phase_nxt = phase_r;
    first_nxt = first_r; depth_nxt = depth_r; hit_nxt = hit_r; oh_nxt = oh_r;
    os_nxt = os_r; ovalid_nxt = ovalid_r; rdy_nxt = rdy_r;
    rd_addr = ptr_i_r; wr_addr = ptr_i_r; wr_data = rd_r; wr_en = 1'b0;
    dreq.start = 1'b0;
    dreq.dividend = {10'd0, ts_r} * {32'd0, rtpjb_pkg::MsPerSec};
    dreq.divisor = (rate_r == '0) ? 18'd1 : rate_r;
    transit = now_r - drsp.quotient[31:0];
    udiff = transit - ptr_r;
    dabs = udiff[31] ? (32'd0 - udiff) : udiff;
    stepd = ($signed({1'b0, dabs}) - $signed({1'b0, jit_r})) / 33'sd16;
    gap = seq_r - (seqst_r ? nexp_r : seq_r);
    up17 = {1'b0, dly_r} + {1'b0, rtpjb_pkg::DelayUp};
    up16 = up17[15:0];

    if (cfg_valid) begin
      case (cfg_index)
        rtpjb_pkg::REG_RATE:       rate_nxt = cfg_data;
        rtpjb_pkg::REG_MIN_DELAY:  min_nxt = cfg_data[15:0];
        rtpjb_pkg::REG_MAX_DELAY:  max_nxt = cfg_data[15:0];
        rtpjb_pkg::REG_INIT_DELAY: init_nxt = cfg_data[15:0];
        default: ;
      endcase
    end
    if (out_tready) ovalid_nxt = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid && in_tready) begin
          func_nxt = in_tuser; seq_nxt = in_tdata[15:0]; ts_nxt = in_tdata[47:16];
          now_nxt = in_tdata[79:48]; hnd_nxt = in_tdata[95:80];
          hit_nxt = 1'b0; oh_nxt = '0; os_nxt = '0; phase_nxt = 1'b0;
          case (in_tuser)
            rtpjb_pkg::FUNC_INSERT: state_nxt = S_DIV;
            rtpjb_pkg::FUNC_EXTRACT: begin
              ptr_i_nxt = '0; state_nxt = S_FIND;
            end
            rtpjb_pkg::FUNC_CLEAR: begin
              occ_nxt = '0; nexp_nxt = '0; seqst_nxt = 1'b0; jst_nxt = 1'b0;
              ptr_nxt = '0; jit_nxt = '0; dly_nxt = init_r; loss_nxt = '0;
              rdy_nxt = '0; state_nxt = S_OUT;
            end
            default: state_nxt = S_OUT;
          endcase
        end
      end
      S_DIV: begin
        if (!phase_r) begin
          dreq.start = 1'b1; phase_nxt = 1'b1;
        end else if (drsp.done) begin
          phase_nxt = 1'b0; state_nxt = S_JIT;
        end
      end
      S_JIT: begin
        if (!jst_r) begin
          jst_nxt = 1'b1; jit_nxt = '0;
        end else begin
          jit_nxt = jit_r + stepd[31:0];
        end
        ptr_nxt = transit;
        if (!seqst_r) seqst_nxt = 1'b1;
        if (gap != 16'd0 && gap < rtpjb_pkg::LossGapLimit) loss_nxt = loss_r + {16'd0, gap};
        if (!gap[15]) nexp_nxt = seq_r + 16'd1;
        ptr_i_nxt = AW'(occ_r);
        phase_nxt = 1'b0;
        state_nxt = S_SHIFT;
      end
      S_SHIFT: begin
        // Walk down from the tail, moving larger entries up one slot.
        rd_addr = ptr_i_r - AW'(1);
        if (ptr_i_r == '0) begin
          wr_en = 1'b1; wr_data = {hnd_r, now_r, seq_r};
          rdy_nxt[ptr_i_r] = 1'b0; occ_nxt = occ_r + CW'(1);
          ptr_i_nxt = '0; phase_nxt = 1'b0; state_nxt = S_DEPTH;
        end else if (!phase_r) begin
          phase_nxt = 1'b1;
        end else if (rd_r[15:0] > seq_r) begin
          wr_en = 1'b1; rdy_nxt[ptr_i_r] = rdy_r[ptr_i_r - AW'(1)];
          ptr_i_nxt = ptr_i_r - AW'(1); phase_nxt = 1'b0;
        end else begin
          wr_en = 1'b1; wr_data = {hnd_r, now_r, seq_r};
          rdy_nxt[ptr_i_r] = 1'b0; occ_nxt = occ_r + CW'(1);
          ptr_i_nxt = '0; phase_nxt = 1'b0; state_nxt = S_DEPTH;
        end
      end
      S_DEPTH: begin
        // Two reads: first and last arrival.
        rd_addr = phase_r ? AW'(occ_r - CW'(1)) : '0;
        if (!phase_r) begin
          phase_nxt = 1'b1;
        end else begin
          first_nxt = rd_r[47:16]; phase_nxt = 1'b0; ptr_i_nxt = '0;
          state_nxt = S_READY;
        end
      end
      S_READY: begin
        rd_addr = ptr_i_r;
        if (!phase_r) begin
          phase_nxt = 1'b1;
          if (ptr_i_r == '0)
            depth_nxt = (occ_r >= CW'(2)) ? (rd_r[47:16] - first_r) : 32'd0;
        end else begin
          rdy_nxt[ptr_i_r] = (now_r - rd_r[47:16]) >= {16'd0, dly_r};
          phase_nxt = 1'b0;
          if (CW'(ptr_i_r) == occ_r - CW'(1)) state_nxt = S_ADAPT;
          else ptr_i_nxt = ptr_i_r + AW'(1);
        end
      end
      S_ADAPT: begin
        if (jit_r > {16'd0, dly_r}) begin
          dly_nxt = (up17 < {1'b0, max_r}) ? up16 : max_r;
        end else if (dly_r > min_r && depth_r < {17'd0, dly_r[15:1]}) begin
          dly_nxt = ($signed({1'b0, dly_r}) - 17'sd5 > $signed({1'b0, min_r}))
                    ? (dly_r - rtpjb_pkg::DelayDown) : min_r;
        end
        ptr_i_nxt = '0; phase_nxt = 1'b0;
        if (occ_r > CW'(MAX_ENTRIES)) begin
          loss_nxt = loss_nxt + 32'd1; state_nxt = S_FIND;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_FIND: begin
        // Insert overflow takes slot 0; extract takes first ready slot.
        rd_addr = ptr_i_r;
        if (CW'(ptr_i_r) >= occ_r) begin
          state_nxt = S_OUT;
        end else if (func_r == rtpjb_pkg::FUNC_EXTRACT && !rdy_r[ptr_i_r]) begin
          ptr_i_nxt = ptr_i_r + AW'(1);
        end else if (!phase_r) begin
          phase_nxt = 1'b1;
        end else begin
          hit_nxt = 1'b1; oh_nxt = rd_r[63:48]; os_nxt = rd_r[15:0];
          phase_nxt = 1'b0; state_nxt = S_REMOVE;
        end
      end
      S_REMOVE: begin
        rd_addr = ptr_i_r + AW'(1);
        if (CW'(ptr_i_r) + CW'(1) >= occ_r) begin
          occ_nxt = occ_r - CW'(1); state_nxt = S_OUT;
        end else if (!phase_r) begin
          phase_nxt = 1'b1;
        end else begin
          wr_en = 1'b1; rdy_nxt[ptr_i_r] = rdy_r[ptr_i_r + AW'(1)];
          ptr_i_nxt = ptr_i_r + AW'(1); phase_nxt = 1'b0;
        end
      end
      S_OUT: begin
        ovalid_nxt = 1'b1; state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    func_r <= func_nxt; seq_r <= seq_nxt; hnd_r <= hnd_nxt; ts_r <= ts_nxt;
    now_r <= now_nxt; first_r <= first_nxt; depth_r <= depth_nxt;
    oh_r <= oh_nxt; os_r <= os_nxt; ptr_i_r <= ptr_i_nxt;
    if (!rst_n) begin
      state_r <= S_IDLE; rate_r <= rtpjb_pkg::RateRst; min_r <= rtpjb_pkg::MinDelayRst;
      max_r <= rtpjb_pkg::MaxDelayRst; init_r <= rtpjb_pkg::InitDelayRst;
      occ_r <= '0; nexp_r <= '0; seqst_r <= 1'b0; jst_r <= 1'b0; ptr_r <= '0;
      jit_r <= '0; dly_r <= rtpjb_pkg::InitDelayRst; loss_r <= '0; phase_r <= 1'b0;
      hit_r <= 1'b0; ovalid_r <= 1'b0; rdy_r <= '0;
    end else begin
      state_r <= state_nxt; rate_r <= rate_nxt; min_r <= min_nxt; max_r <= max_nxt;
      init_r <= init_nxt; occ_r <= occ_nxt; nexp_r <= nexp_nxt; seqst_r <= seqst_nxt;
      jst_r <= jst_nxt; ptr_r <= ptr_nxt; jit_r <= jit_nxt; dly_r <= dly_nxt;
      loss_r <= loss_nxt; phase_r <= phase_nxt; hit_r <= hit_nxt;
      ovalid_r <= ovalid_nxt; rdy_r <= rdy_nxt;
    end
  end

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> occ_r <= CW'(MAX_ENTRIES)) else $error("fill above capacity");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> !in_tready) else $error("ready while busy");
  a_out_after_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ovalid_r) |-> $past(state_r) == S_OUT) else $error("result outside out state");
  a_delay_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    $past(state_r) == S_ADAPT && $past(jit_r) > {16'd0, $past(dly_r)}
    |-> dly_r >= $past(dly_r) || dly_r == max_r) else $error("delay step wrong");
endmodule
`default_nettype wire

[src/rtpjb_div.sv]
// Restoring bit-serial divider, one quotient bit per cycle.
`default_nettype none
module rtpjb_div (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire rtpjb_pkg::div_req_t req,
  output rtpjb_pkg::div_rsp_t     rsp
);
  logic [41:0] quo_r, quo_nxt;
  logic [17:0] rem_r, rem_nxt;
  logic [17:0] dvs_r, dvs_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [18:0] trial;

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, quo_r[41]};
    if (req.start) begin
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
      cnt_nxt  = 6'd42;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // remainder stays below the divisor, so it fits in 18 bits
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = 18'(trial - {1'b0, dvs_r});
        quo_nxt = {quo_r[40:0], 1'b1};
      end else begin
        rem_nxt = trial[17:0];
        quo_nxt = {quo_r[40:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r)) else $error("divider done without busy");
  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !busy_r) else $error("divider restarted while busy");
  a_cnt_live: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> cnt_r != 6'd0) else $error("divider count underflow");
endmodule
`default_nettype wire

[tb/testbench.sv]
// Self-checking testbench for rtp_jitter_buffer: directed and random streams against a predictor.
`timescale 1ns / 1ps
module testbench;

  localparam int unsigned Depth = rtpjb_pkg::MaxEntriesDef;
  localparam int unsigned Slots = Depth + 1;   // one staging slot for the arriving entry
  localparam int unsigned SettleCycles = 300;  // idle gap after a drain
  localparam int unsigned ExpDepth = 8;        // expected results in flight, at most one

  // Laid out as on out_tdata: first member is the top bits.
  typedef struct packed {
    logic [6:0]  fill;
    logic [31:0] lost;
    logic [31:0] jitter;
    logic [15:0] delay;
    logic [15:0] seq;
    logic [15:0] handle;
    logic        hit;
  } status_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [95:0]  in_tdata = '0;
  logic [1:0]   in_tuser = rtpjb_pkg::FUNC_NOP;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [127:0] out_tdata;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [1:0]   cfg_index = rtpjb_pkg::REG_RATE;
  logic [17:0]  cfg_data = '0;

  always #2 clk = ~clk;

  rtp_jitter_buffer dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Register shadow
  logic [17:0] rate_reg;
  logic [15:0] min_reg, max_reg, init_reg;

  // Shadow of the sorted descriptor store and the statistics
  logic [15:0] slot_sq[Slots];
  logic [31:0] slot_arr[Slots];
  logic [15:0] slot_hd[Slots];
  bit          slot_rdy[Slots];
  int unsigned fill;
  logic [15:0] seq_next;
  bit          seq_on, jit_on;
  logic [31:0] transit_prev, jitter_est, lost_cnt, delay_cur;

  // Expected results, ring buffer with free-running counters
  status_t     exp_buf[ExpDepth];
  int unsigned exp_wr = 0;
  int unsigned exp_rd = 0;
  int unsigned errors = 0;
  bit steady = 1'b0;  // suppresses random idling on both sides

  // Stream state for well-formed packet flow
  logic [15:0] s_seq;
  logic [31:0] s_ts, s_now;
  logic [15:0] s_hd;

  function automatic void clear_state();
    fill = 0;
    seq_next = '0;
    seq_on = 1'b0;
    jit_on = 1'b0;
    transit_prev = '0;
    jitter_est = '0;
    delay_cur = {16'd0, init_reg};
    lost_cnt = '0;
    foreach (slot_rdy[i]) slot_rdy[i] = 1'b0;
  endfunction

  function automatic void drop_slot(int unsigned pos);
    for (int unsigned i = pos; i + 1 < fill; i++) begin
      slot_sq[i] = slot_sq[i+1];
      slot_arr[i] = slot_arr[i+1];
      slot_hd[i] = slot_hd[i+1];
      slot_rdy[i] = slot_rdy[i+1];
    end
    fill--;
  endfunction

  // Next status for one operation; state is advanced in place.
  function automatic status_t buffer_step(rtpjb_pkg::func_t f, logic [15:0] sq,
                                          logic [31:0] ts, logic [31:0] now,
                                          logic [15:0] hd);
    status_t r;
    logic [31:0] rate, media, transit, u, depth, gap32;
    logic [15:0] gap;
    longint d, step;
    int unsigned pos;
    r = '0;
    case (f)
      rtpjb_pkg::FUNC_INSERT: begin
        rate = (rate_reg == 0) ? 32'd1 : {14'd0, rate_reg};
        media = 32'((64'(ts) * 64'd1000) / 64'(rate));
        transit = now - media;
        if (!jit_on) begin
          // first packet only records its transit
          jit_on = 1'b1;
          transit_prev = transit;
          jitter_est = '0;
        end else begin
          u = transit - transit_prev;
          d = longint'($signed(u));
          if (d < 0) d = -d;
          step = (d - longint'(jitter_est)) / 16;
          jitter_est = 32'(longint'(jitter_est) + step);
          transit_prev = transit;
        end
        if (!seq_on) begin
          seq_next = sq;
          seq_on = 1'b1;
        end
        gap = sq - seq_next;
        gap32 = {16'd0, gap};
        if (gap > 0 && gap < rtpjb_pkg::LossGapLimit) lost_cnt += gap32;
        if (gap < 16'h8000) seq_next = sq + 16'd1;
        pos = fill;
        while (pos > 0 && slot_sq[pos-1] > sq) begin
          slot_sq[pos] = slot_sq[pos-1];
          slot_arr[pos] = slot_arr[pos-1];
          slot_hd[pos] = slot_hd[pos-1];
          slot_rdy[pos] = slot_rdy[pos-1];
          pos--;
        end
        slot_sq[pos] = sq;
        slot_arr[pos] = now;
        slot_hd[pos] = hd;
        fill++;
        depth = (fill >= 2) ? slot_arr[fill-1] - slot_arr[0] : 32'd0;
        for (int unsigned i = 0; i < fill; i++)
          slot_rdy[i] = (now - slot_arr[i]) >= delay_cur;
        if (jitter_est > delay_cur) begin
          delay_cur = (delay_cur + 10 < {16'd0, max_reg}) ? delay_cur + 10 : {16'd0, max_reg};
        end else if (delay_cur > {16'd0, min_reg} && depth < delay_cur / 2) begin
          delay_cur = (int'(delay_cur) - 5 > int'({16'd0, min_reg})) ? delay_cur - 5
                                                                     : {16'd0, min_reg};
        end
        if (fill > Depth) begin
          // overflow: lowest entry goes, maybe the new one
          r.hit = 1'b1;
          r.handle = slot_hd[0];
          r.seq = slot_sq[0];
          drop_slot(0);
          lost_cnt++;
        end
      end
      rtpjb_pkg::FUNC_EXTRACT: begin
        for (int unsigned i = 0; i < fill; i++) begin
          if (slot_rdy[i]) begin
            r.hit = 1'b1;
            r.handle = slot_hd[i];
            r.seq = slot_sq[i];
            drop_slot(i);
            break;
          end
        end
      end
      rtpjb_pkg::FUNC_CLEAR: clear_state();
      default: ;
    endcase
    r.delay = delay_cur[15:0];
    r.jitter = jitter_est;
    r.lost = lost_cnt;
    r.fill = 7'(fill);
    return r;
  endfunction

  // One input transaction; valid stays high on return so back-to-back sends need no re-raise.
  task automatic send_op(rtpjb_pkg::func_t f, logic [15:0] sq, logic [31:0] ts,
                         logic [31:0] now, logic [15:0] hd);
    if (!steady && $urandom_range(99) < 26) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= f;
    in_tdata <= {hd, now, ts, sq};
    do @(posedge clk); while (!in_tready);
    exp_buf[exp_wr % ExpDepth] = buffer_step(f, sq, ts, now, hd);
    exp_wr++;
  endtask

  // Blocks until every result is back, then lets the block settle.
  task automatic drain();
    in_tvalid <= 1'b0;
    wait (exp_wr == exp_rd);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(rtpjb_pkg::reg_idx_t idx, logic [17:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      rtpjb_pkg::REG_RATE:       rate_reg = val;
      rtpjb_pkg::REG_MIN_DELAY:  min_reg = val[15:0];
      rtpjb_pkg::REG_MAX_DELAY:  max_reg = val[15:0];
      rtpjb_pkg::REG_INIT_DELAY: init_reg = val[15:0];
      default: ;
    endcase
  endtask

  // Upper cfg_data bits are junk for the 16-bit registers; the block must ignore them.
  task automatic write_all(logic [17:0] rate, logic [15:0] mn, logic [15:0] mx, logic [15:0] ini);
    write_reg(rtpjb_pkg::REG_RATE, rate);
    write_reg(rtpjb_pkg::REG_MIN_DELAY, {2'($urandom_range(3)), mn});
    write_reg(rtpjb_pkg::REG_MAX_DELAY, {2'($urandom_range(3)), mx});
    write_reg(rtpjb_pkg::REG_INIT_DELAY, {2'($urandom_range(3)), ini});
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic stream_restart();
    s_seq = 16'($urandom);
    s_ts = $urandom;
    s_now = $urandom;
    s_hd = 16'($urandom);
  endtask

  // Mostly in-order packet flow with loss, reordering and jitter; some noise and clears.
  task automatic test_packet_flow(int n, int ins_pct, int jit);
    int sel;
    logic [15:0] sq;
    for (int k = 0; k < n; k++) begin
      sel = $urandom_range(99);
      s_now += 32'($urandom_range(25, 1));
      if (sel < ins_pct) begin
        sq = s_seq;
        case ($urandom_range(19))
          0: s_seq += 16'($urandom_range(120, 2));  // lost run, sometimes beyond the loss window
          1: sq = s_seq - 16'($urandom_range(5, 1)); // late packet
          2: sq = s_seq;                              // next in order, like the default
          default: s_seq += 16'd1;
        endcase
        if (sq == s_seq) s_seq += 16'd1;
        s_ts += 32'd160;
        s_hd += 16'd1;
        send_op(rtpjb_pkg::FUNC_INSERT, sq, s_ts + 32'($urandom_range(jit)), s_now, s_hd);
      end else if (sel < 96) begin
        send_op(rtpjb_pkg::FUNC_EXTRACT, 16'($urandom), $urandom, s_now, 16'($urandom));
      end else if (sel < 98) begin
        send_op(rtpjb_pkg::FUNC_INSERT, 16'($urandom), $urandom, $urandom, 16'($urandom));
      end else if (sel < 99) begin
        send_op(rtpjb_pkg::FUNC_NOP, 16'($urandom), $urandom, $urandom, 16'($urandom));
      end else begin
        send_op(rtpjb_pkg::FUNC_CLEAR, 16'($urandom), $urandom, s_now, 16'($urandom));
      end
    end
  endtask

  // Field extremes, equal and wrapped sequence numbers, loss window edges, all functions.
  task automatic test_directed();
    send_op(rtpjb_pkg::FUNC_EXTRACT, 16'h0000, 32'h0, 32'h0, 16'h0);          // empty store
    send_op(rtpjb_pkg::FUNC_INSERT, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
    send_op(rtpjb_pkg::FUNC_INSERT, 16'h0000, 32'h0, 32'h0000_0005, 16'h0000); // wraps to seq 0
    send_op(rtpjb_pkg::FUNC_INSERT, 16'h0000, 32'h0000_00A0, 32'h0000_0030, 16'h1111); // equal
    send_op(rtpjb_pkg::FUNC_INSERT, 16'd99, 32'h0000_0140, 32'h0000_0040, 16'h2222);   // gap 98
    send_op(rtpjb_pkg::FUNC_INSERT, 16'd200, 32'h0000_0200, 32'h0000_0050, 16'h3333);  // gap 100
    send_op(rtpjb_pkg::FUNC_INSERT, 16'd150, 32'h0000_0300, 32'h0000_0060, 16'h4444);  // backwards
    send_op(rtpjb_pkg::FUNC_INSERT, 16'd201, 32'h8000_0000, 32'h0000_0070, 16'h5555);  // big jump
    send_op(rtpjb_pkg::FUNC_EXTRACT, 16'h0, 32'h0, 32'h0000_0070, 16'h0);
    send_op(rtpjb_pkg::FUNC_INSERT, 16'd202, 32'h0000_0400, 32'h0001_0000, 16'h6666);  // ready
    send_op(rtpjb_pkg::FUNC_EXTRACT, 16'h0, 32'h0, 32'h0001_0000, 16'h0);
    send_op(rtpjb_pkg::FUNC_EXTRACT, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
    send_op(rtpjb_pkg::FUNC_NOP, 16'hA5A5, 32'h5A5A_A5A5, 32'hA5A5_5A5A, 16'h5A5A);
    send_op(rtpjb_pkg::FUNC_CLEAR, 16'h0, 32'h0, 32'h0, 16'h0);
    send_op(rtpjb_pkg::FUNC_INSERT, 16'h7FFF, 32'h1234_5678, 32'h0000_0010, 16'hABCD); // first
    send_op(rtpjb_pkg::FUNC_INSERT, 16'h8000, 32'h1234_56F8, 32'h0000_0020, 16'hBCDE);
    send_op(rtpjb_pkg::FUNC_INSERT, 16'h7FFE, 32'h1234_5778, 32'h0000_0030, 16'hCDEF);
    send_op(rtpjb_pkg::FUNC_EXTRACT, 16'h0, 32'h0, 32'h0000_1000, 16'h0);
  endtask

  // Fills past capacity so overflow drops happen, including the new entry being lowest.
  task automatic test_overflow();
    for (int k = 0; k < 90; k++) begin
      s_now += 32'd2;
      s_ts += 32'd160;
      s_hd += 16'd1;
      s_seq += 16'd1;
      send_op(rtpjb_pkg::FUNC_INSERT, (k % 9 == 8) ? 16'd0 : s_seq, s_ts, s_now, s_hd);
    end
    for (int k = 0; k < 40; k++) begin
      s_now += 32'd50;
      send_op(rtpjb_pkg::FUNC_EXTRACT, 16'h0, 32'h0, s_now, 16'h0);
    end
  endtask

  // Result checker; the receiver stalls at random except in steady stretches.
  always @(posedge clk) begin
    status_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = status_t'(out_tdata[119:0]);
      if (exp_wr == exp_rd) begin
        $error("result with no operation outstanding: %h", out_tdata);
        errors++;
      end else begin
        want = exp_buf[exp_rd % ExpDepth];
        exp_rd++;
        if (got.hit != want.hit) begin
          $error("hit: expected %0d, got %0d", want.hit, got.hit); errors++;
        end
        if (got.handle != want.handle) begin
          $error("out_handle: expected %0h, got %0h", want.handle, got.handle); errors++;
        end
        if (got.seq != want.seq) begin
          $error("out_seq: expected %0d, got %0d", want.seq, got.seq); errors++;
        end
        if (got.delay != want.delay) begin
          $error("delay_now_ms: expected %0d, got %0d", want.delay, got.delay); errors++;
        end
        if (got.jitter != want.jitter) begin
          $error("jitter_now_ms: expected %0d, got %0d", want.jitter, got.jitter); errors++;
        end
        if (got.lost != want.lost) begin
          $error("lost_total: expected %0d, got %0d", want.lost, got.lost); errors++;
        end
        if (got.fill != want.fill) begin
          $error("fill_count: expected %0d, got %0d", want.fill, got.fill); errors++;
        end
        if (out_tdata[127:120] != 8'h0) begin
          $error("tdata pad: expected 0, got %0h", out_tdata[127:120]); errors++;
        end
      end
    end
    out_tready <= steady ? 1'b1 : ($urandom_range(99) >= 26);
  end

  initial begin
    rate_reg = rtpjb_pkg::RateRst;
    min_reg = rtpjb_pkg::MinDelayRst;
    max_reg = rtpjb_pkg::MaxDelayRst;
    init_reg = rtpjb_pkg::InitDelayRst;
    clear_state();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    drain();
    stream_restart();
    test_packet_flow(250, 55, 400);
    steady = 1'b1;  // back-to-back stretch on both sides
    test_packet_flow(250, 55, 400);
    steady = 1'b0;
    test_packet_flow(200, 60, 4000);
    drain();

    // fastest rate, widest delay range, zero initial delay
    write_all(18'd192000, 16'd0, 16'hFFFF, 16'd0);
    send_op(rtpjb_pkg::FUNC_CLEAR, 16'h0, 32'h0, 32'h0, 16'h0);
    stream_restart();
    test_packet_flow(400, 55, 100000);
    drain();

    // zero rate (behaves as one), bounds crossed, initial delay at top
    write_all(18'd0, 16'hFFFF, 16'd0, 16'hFFFF);
    send_op(rtpjb_pkg::FUNC_CLEAR, 16'h0, 32'h0, 32'h0, 16'h0);
    stream_restart();
    test_packet_flow(150, 55, 2);
    drain();
    write_all(18'd1, 16'd0, 16'd0, 16'd0);
    send_op(rtpjb_pkg::FUNC_CLEAR, 16'h0, 32'h0, 32'h0, 16'h0);
    test_packet_flow(150, 55, 2);
    drain();

    // narrow delay window, then overflow the store
    write_all(18'($urandom_range(192000, 1)), 16'd5, 16'd40, 16'd30);
    send_op(rtpjb_pkg::FUNC_CLEAR, 16'h0, 32'h0, 32'h0, 16'h0);
    stream_restart();
    test_overflow();
    test_packet_flow(250, 50, 300);
    drain();

    if (errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("testbench: done, errors");
    $finish;
  end

endmodule
